>>> rtl/sync_frame_text_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame text parser
// Clocked, reset-qualified implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_TEXT_PARSER_ASSERT_SVH
`define SYNC_FRAME_TEXT_PARSER_ASSERT_SVH

// same-cycle implication
`define SFTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sftp_pkg.sv
// ----------------------------------------------------------------------------
// sftp_pkg
// Types, status codes and character constants of the frame text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sftp_pkg;

    typedef enum logic [5:0] {
        PH_PREFIX  = 6'b000001,
        PH_SESSION = 6'b000010,
        PH_COLON   = 6'b000100,
        PH_INDEX   = 6'b001000,
        PH_TOTAL   = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_HEADER = 3'd1;
    localparam status_t ST_RANGE  = 3'd2;
    localparam status_t ST_LENGTH = 3'd3;
    localparam status_t ST_HEX    = 3'd4;

    localparam logic [1:0] REG_PREFIX_CHARS  = 2'd0;
    localparam logic [1:0] REG_PREFIX_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX_TOTAL     = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd3;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] DIGIT_BASE   = 8'd10;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    localparam logic [7:0]  RESET_MAX_TOTAL   = 8'd64;
    localparam logic [7:0]  RESET_MAX_PAYLOAD = 8'd128;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = {1'b0, c[3:0]};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            r = {1'b0, 4'(c - CHAR_UPPER_A + DIGIT_BASE)};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            r = {1'b0, 4'(c - CHAR_LOWER_A + DIGIT_BASE)};
        end else begin
            r = 5'b10000;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // acc * 10 + d
    function automatic logic [9:0] dec_step(input logic [9:0] acc, input logic [3:0] d);
        return 10'({acc, 3'b000} + {acc, 1'b0} + {6'd0, d});
    endfunction

endpackage

`default_nettype wire

>>> rtl/sync_frame_text_parser.sv
// ----------------------------------------------------------------------------
// sync_frame_text_parser
// Parses prefix, session id, index/total header and hex payload of a text
// frame, one character per word; emits payload bytes and a closing status.
// ----------------------------------------------------------------------------
// Takes one character word per clock and, when the output side keeps up,
// never stalls: each word is decoded combinationally against the frame
// state and its result, if any, is registered in the output register on
// acceptance. s_ready is high whenever the output register is empty or being
// drained, so a held result only stalls input while m_ready stays low.
// A payload byte goes out on the word carrying its second hex digit; the
// end-of-text word gives one status word and returns the frame state to reset.
// Register map (64-bit data): 0x00 prefix_chars, 0x08 prefix_length,
// 0x10 max_total_frames, 0x18 max_payload_bytes.
`default_nettype none
`include "sync_frame_text_parser_assert.svh"

module sync_frame_text_parser #(
    parameter int PREFIX_MAX = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_character,
    input  wire logic        s_end_of_text,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_payload_byte,
    output sftp_pkg::status_t m_status,
    output logic [31:0]      m_session_id,
    output logic [7:0]       m_frame_index,
    output logic [7:0]       m_total_frames,
    output logic [7:0]       m_payload_length
);
    import sftp_pkg::*;

    localparam logic [3:0] PrefixMaxW = 4'(PREFIX_MAX);

    // configuration
    logic [63:0] prefix_chars_reg;
    logic [3:0]  prefix_length_reg;
    logic [7:0]  max_total_reg;
    logic [7:0]  max_payload_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] sess_reg, sess_next;
    logic [9:0]  idx_reg, idx_next;
    logic [9:0]  tot_reg, tot_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [3:0]  hi_reg, hi_next;
    status_t     err_reg, err_next;
    logic        bad_reg, bad_next;

    // output register
    logic        m_valid_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    status_t     status_reg;
    logic [31:0] sid_reg;
    logic [7:0]  fidx_reg;
    logic [7:0]  ftot_reg;
    logic [7:0]  plen_reg;

    logic        accept;
    logic        cfg_wr;
    logic        emit;
    logic        res_kind;
    logic [7:0]  res_byte;
    status_t     res_status;
    logic [31:0] res_sid;
    logic [7:0]  res_idx;
    logic [7:0]  res_tot;
    logic [7:0]  res_len;

    logic [3:0]  plen_eff;
    logic [7:0]  want_char;
    logic [4:0]  nib;
    logic        in_prefix;
    phase_t      work_phase;
    logic [3:0]  work_pos;
    logic [3:0]  pos_inc;
    logic [8:0]  cnt_inc;
    status_t     end_status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        unique case (paddr[4:3])
            REG_PREFIX_CHARS:  prdata = prefix_chars_reg;
            REG_PREFIX_LENGTH: prdata = {60'd0, prefix_length_reg};
            REG_MAX_TOTAL:     prdata = {56'd0, max_total_reg};
            REG_MAX_PAYLOAD:   prdata = {56'd0, max_payload_reg};
            default:           prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_chars_reg  <= 64'd0;
            prefix_length_reg <= 4'd0;
            max_total_reg     <= RESET_MAX_TOTAL;
            max_payload_reg   <= RESET_MAX_PAYLOAD;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_PREFIX_CHARS:  prefix_chars_reg  <= pwdata;
                REG_PREFIX_LENGTH: prefix_length_reg <= pwdata[3:0];
                REG_MAX_TOTAL:     max_total_reg     <= pwdata[7:0];
                REG_MAX_PAYLOAD:   max_payload_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign plen_eff   = (prefix_length_reg > PrefixMaxW) ? PrefixMaxW : prefix_length_reg;
    assign want_char  = prefix_chars_reg[{pos_reg[2:0], 3'b000} +: 8];
    assign nib        = nibble_of(s_character);
    assign in_prefix  = (phase_reg == PH_PREFIX) && (pos_reg < plen_eff);
    assign work_phase = (phase_reg == PH_PREFIX) ? PH_SESSION : phase_reg;
    assign work_pos   = (phase_reg == PH_PREFIX) ? 4'd0 : pos_reg;
    assign pos_inc    = work_pos + 4'd1;
    assign cnt_inc    = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 9'd1;

    always_comb begin
        priority if (err_reg != ST_OK) begin
            end_status = err_reg;
        end else if (phase_reg != PH_PAYLOAD) begin
            end_status = ST_HEADER;
        end else if (cnt_reg == 9'd0 || cnt_reg[0] || cnt_reg[8:1] > max_payload_reg) begin
            end_status = ST_LENGTH;
        end else if (bad_reg) begin
            end_status = ST_HEX;
        end else begin
            end_status = ST_OK;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sess_next  = sess_reg;
        idx_next   = idx_reg;
        tot_next   = tot_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        err_next   = err_reg;
        bad_next   = bad_reg;
        emit       = 1'b0;
        res_kind   = 1'b0;
        res_byte   = 8'd0;
        res_status = ST_OK;
        res_sid    = 32'd0;
        res_idx    = 8'd0;
        res_tot    = 8'd0;
        res_len    = 8'd0;

        if (accept) begin
            if (s_end_of_text) begin
                emit       = 1'b1;
                res_kind   = 1'b1;
                res_status = end_status;
                res_sid    = (end_status == ST_HEADER) ? 32'd0 : sess_reg;
                if (end_status == ST_OK) begin
                    res_idx = idx_reg[7:0];
                    res_tot = tot_reg[7:0];
                    res_len = cnt_reg[8:1];
                end
                phase_next = PH_PREFIX;
                pos_next   = 4'd0;
                sess_next  = 32'd0;
                idx_next   = 10'd0;
                tot_next   = 10'd0;
                cnt_next   = 9'd0;
                hi_next    = 4'd0;
                err_next   = ST_OK;
                bad_next   = 1'b0;
            end else if (err_reg == ST_OK) begin
                if (in_prefix) begin
                    if (s_character != want_char) begin
                        err_next = ST_HEADER;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end else begin
                    unique case (work_phase)
                        PH_SESSION: begin
                            if (nib[4]) begin
                                err_next = ST_HEADER;
                            end else begin
                                sess_next = {sess_reg[27:0], nib[3:0]};
                                if (pos_inc >= 4'd8) begin
                                    phase_next = PH_COLON;
                                    pos_next   = 4'd0;
                                end else begin
                                    phase_next = PH_SESSION;
                                    pos_next   = pos_inc;
                                end
                            end
                        end
                        PH_COLON: begin
                            if (s_character == CHAR_COLON) begin
                                phase_next = PH_INDEX;
                                pos_next   = 4'd0;
                            end else begin
                                err_next = ST_HEADER;
                            end
                        end
                        PH_INDEX: begin
                            if (is_digit(s_character) && work_pos < 4'd3) begin
                                idx_next = dec_step(idx_reg, s_character[3:0]);
                                pos_next = pos_inc;
                            end else if (s_character == CHAR_SLASH) begin
                                phase_next = PH_TOTAL;
                                pos_next   = 4'd0;
                            end else begin
                                err_next = ST_HEADER;
                            end
                        end
                        PH_TOTAL: begin
                            if (is_digit(s_character) && work_pos < 4'd3) begin
                                tot_next = dec_step(tot_reg, s_character[3:0]);
                                pos_next = pos_inc;
                            end else if (s_character == CHAR_COLON) begin
                                phase_next = PH_PAYLOAD;
                                pos_next   = 4'd0;
                                if (tot_reg == 10'd0 || idx_reg >= tot_reg
                                    || tot_reg > {2'b00, max_total_reg}) begin
                                    err_next = ST_RANGE;
                                end
                            end else begin
                                err_next = ST_HEADER;
                            end
                        end
                        PH_PAYLOAD: begin
                            cnt_next = cnt_inc;
                            if (nib[4]) begin
                                bad_next = 1'b1;
                            end else if (cnt_inc[0]) begin
                                hi_next = nib[3:0];
                            end else if (!bad_reg && cnt_inc[8:1] <= max_payload_reg) begin
                                emit     = 1'b1;
                                res_byte = {hi_reg, nib[3:0]};
                            end
                        end
                        default: begin
                            err_next = ST_HEADER;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= 4'd0;
            sess_reg  <= 32'd0;
            idx_reg   <= 10'd0;
            tot_reg   <= 10'd0;
            cnt_reg   <= 9'd0;
            hi_reg    <= 4'd0;
            err_reg   <= ST_OK;
            bad_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sess_reg  <= sess_next;
            idx_reg   <= idx_next;
            tot_reg   <= tot_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            err_reg   <= err_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            kind_reg   <= res_kind;
            byte_reg   <= res_byte;
            status_reg <= res_status;
            sid_reg    <= res_sid;
            fidx_reg   <= res_idx;
            ftot_reg   <= res_tot;
            plen_reg   <= res_len;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_payload_byte   = byte_reg;
    assign m_status         = status_reg;
    assign m_session_id     = sid_reg;
    assign m_frame_index    = fidx_reg;
    assign m_total_frames   = ftot_reg;
    assign m_payload_length = plen_reg;

    `SFTP_ASSERT_NOW(a_ok_status_sane, aclk, aresetn,
        m_valid && m_kind && m_status == ST_OK,
        m_payload_length != 8'd0 && m_total_frames > m_frame_index,
        "ok status with empty payload or index not below total")

    `SFTP_ASSERT_NOW(a_byte_word_clean, aclk, aresetn,
        m_valid && !m_kind,
        m_status == ST_OK && m_session_id == 32'd0 && m_payload_length == 8'd0,
        "payload byte word carries status fields")

    `SFTP_ASSERT_NEXT(a_end_clears_frame, aclk, aresetn,
        accept && s_end_of_text,
        phase_reg == PH_PREFIX && err_reg == ST_OK && cnt_reg == 9'd0 && m_valid && m_kind,
        "end of text did not close the frame")

endmodule

`default_nettype wire
